@@ src/dlcs_pkg.sv @@
// shared types, constants and the base decode for the dust scorer
package dlcs_pkg;

    localparam int CFG_W    = 7;
    localparam int BASE_W   = 4;
    localparam int TRIP_W   = 6;
    localparam int TRIP_N   = 64;
    localparam int CNT_W    = 16;
    localparam int SCORE_W  = 15;
    localparam int PEAK_W   = 11;
    localparam int W_MIN    = 3;

    localparam logic [CFG_W-1:0]   W_RESET  = 7'd64;
    localparam logic [SCORE_W-1:0] PCT_MAX  = 15'h7fff;
    localparam logic [PEAK_W-1:0]  PEAK_MAX = 11'h7ff;
    localparam logic [CNT_W-1:0]   CNT_MAX  = 16'hffff;

    // decoded base: bit 2 set means the nibble is not a base
    localparam logic [2:0] BASE_A    = 3'd0;
    localparam logic [2:0] BASE_C    = 3'd1;
    localparam logic [2:0] BASE_G    = 3'd2;
    localparam logic [2:0] BASE_T    = 3'd3;
    localparam logic [2:0] BASE_SKIP = 3'd4;

    localparam logic [BASE_W-1:0] NIB_A = 4'h1;
    localparam logic [BASE_W-1:0] NIB_C = 4'h2;
    localparam logic [BASE_W-1:0] NIB_G = 4'h4;
    localparam logic [BASE_W-1:0] NIB_T = 4'h8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_WRT,
        ST_FIN,
        ST_DSTART,
        ST_DWAIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [2:0] base_map(input logic [BASE_W-1:0] nib);
        logic [2:0] code;
        unique case (nib)
            NIB_A:   code = BASE_A;
            NIB_C:   code = BASE_C;
            NIB_G:   code = BASE_G;
            NIB_T:   code = BASE_T;
            default: code = BASE_SKIP;
        endcase
        return code;
    endfunction

endpackage

@@ src/dlcs_base_if.sv @@
// input channel: one base nibble and the end-of-read mark per transfer
interface dlcs_base_if
    import dlcs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base_code;
    logic              last_base;

    modport source (output valid, output base_code, output last_base, input ready);
    modport sink   (input valid, input base_code, input last_base, output ready);
endinterface

@@ src/dlcs_score_if.sv @@
// output channel: one complexity result per read
interface dlcs_score_if
    import dlcs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] dust_score;
    logic [PEAK_W-1:0]  peak_pair_score;
    logic               window_filled;

    modport source (output valid, output dust_score, output peak_pair_score,
                    output window_filled, input ready);
    modport sink   (input valid, input dust_score, input peak_pair_score,
                    input window_filled, output ready);
endinterface

@@ src/dust_low_complexity_score.sv @@
// dust triplet low-complexity scorer: count and ring memories, per-read result
//
//  channel   dir  transfer payload                                   modport
//  i_base    in   base_code[3:0], last_base                          sink
//  o_score   out  dust_score[14:0], peak_pair_score[10:0], filled    source
//  i_cfg     in   i_cfg_wr_en, i_cfg_wr_data[6:0] (window_length)    -
//
// skipped or priming base: ST_IDLE; triplet while the window fills: ST_IDLE, ST_RD1;
// sliding triplet: also ST_RD2, ST_WRT, the count memory read-modify-write of the
// removed and added code. last_base adds ST_FIN, ST_DSTART, ST_DWAIT, 16 divider steps.
// i_rst_n is synchronous; counts clear at once per read through per-entry valid bits.
// a result waiting on o_score stalls the block only when the next result is ready.
module dust_low_complexity_score
    import dlcs_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    dlcs_base_if.sink        i_base,
    dlcs_score_if.source     o_score
);

    localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
    localparam int RING_AW = $clog2(WINDOW_MAX);
    localparam int EXT_W   = (WIN_W > CFG_W) ? WIN_W : CFG_W;
    localparam int NUM_W   = 2 * WIN_W + 1;
    localparam int DEN_W   = 2 * WIN_W;
    localparam int PAIR_W  = CNT_W + WIN_W + 1;
    localparam logic [PAIR_W-1:0] NUM_CAP = PAIR_W'(1) << (2 * WIN_W);

    // memories
    logic [CNT_W-1:0]  cnt_mem  [TRIP_N];
    logic [TRIP_W-1:0] ring_mem [WINDOW_MAX];

    // control registers
    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_window_length;
    logic [TRIP_W-1:0]   r_shift, n_shift;
    logic [1:0]          r_primed, n_primed;
    logic [RING_AW-1:0]  r_pos, n_pos;
    logic [WIN_W-1:0]    r_seen, n_seen;
    logic [PAIR_W-1:0]   r_pair, n_pair;
    logic [PAIR_W-1:0]   r_peak, n_peak;
    logic                r_full, n_full;
    logic [TRIP_N-1:0]   r_cnt_vld;
    logic                r_out_valid, n_out_valid;
    logic                r_slide;
    logic                r_last;

    // payload registers
    logic [TRIP_W-1:0]   r_t;
    logic [TRIP_W-1:0]   r_x;
    logic [RING_AW-1:0]  r_pos_cur;
    logic [CNT_W-1:0]    r_ct;
    logic [CNT_W-1:0]    r_cnt_q;
    logic                r_cnt_qv;
    logic [TRIP_W-1:0]   r_ring_q;
    logic [NUM_W-1:0]    r_num;
    logic [DEN_W-1:0]    r_den;
    logic [PEAK_W-1:0]   r_pk_used;
    logic                r_filled;
    logic [SCORE_W-1:0]  r_out_dust;
    logic [PEAK_W-1:0]   r_out_peak;
    logic                r_out_filled;

    // memory controls
    logic                cnt_rd_en;
    logic [TRIP_W-1:0]   cnt_rd_addr;
    logic                cnt_wr_en;
    logic [TRIP_W-1:0]   cnt_wr_addr;
    logic [CNT_W-1:0]    cnt_wr_data;
    logic                cnt_clear;
    logic                ring_rd_en;
    logic                ring_wr_en;
    logic                out_load;

    // datapath
    logic                in_take;
    logic                out_take;
    logic [2:0]          bmap;
    logic [TRIP_W-1:0]   shift_nx;
    logic [EXT_W-1:0]    w_ext;
    logic [WIN_W-1:0]    w_eff;
    logic [RING_AW-1:0]  pos_eff;
    logic [WIN_W-1:0]    pos_inc;
    logic [RING_AW-1:0]  pos_adv;
    logic [CNT_W-1:0]    cnt_val;
    logic                cx_nz;
    logic [CNT_W-1:0]    cx_new;
    logic [CNT_W-1:0]    ct_eff;
    logic [PAIR_W-1:0]   pair_sub;
    logic [WIN_W-1:0]    fin_sel;
    logic [PAIR_W-1:0]   fin_num;
    logic [DEN_W-1:0]    fin_den;

    logic [SCORE_W-1:0]  div_quot;
    t_div_stat           div_stat;

    function automatic logic [PAIR_W-1:0] pair_add(input logic [PAIR_W-1:0] a,
                                                   input logic [CNT_W-1:0]  b);
        logic [PAIR_W:0] sum;
        sum = {1'b0, a} + (PAIR_W + 1)'(b);
        return sum[PAIR_W] ? {PAIR_W{1'b1}} : sum[PAIR_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    assign i_base.ready = (r_state == ST_IDLE);
    assign in_take      = i_base.valid && i_base.ready;
    assign out_take     = r_out_valid && o_score.ready;

    assign bmap     = base_map(i_base.base_code);
    assign shift_nx = {r_shift[TRIP_W-3:0], bmap[1:0]};

    // window length clamped to 3..WINDOW_MAX
    assign w_ext = EXT_W'(r_window_length);
    always_comb begin
        priority if (w_ext < EXT_W'(W_MIN)) begin
            w_eff = WIN_W'(W_MIN);
        end else if (w_ext > EXT_W'(WINDOW_MAX)) begin
            w_eff = WIN_W'(WINDOW_MAX);
        end else begin
            w_eff = WIN_W'(w_ext);
        end
    end

    assign pos_eff = (WIN_W'(r_pos) >= w_eff) ? '0 : r_pos;
    assign pos_inc = WIN_W'(r_pos_cur) + WIN_W'(1);
    assign pos_adv = (pos_inc >= w_eff) ? '0 : RING_AW'(pos_inc);

    assign cnt_val  = r_cnt_qv ? r_cnt_q : '0;
    assign cx_nz    = (cnt_val != '0);
    assign cx_new   = cx_nz ? cnt_val - 1'b1 : cnt_val;
    assign ct_eff   = (r_x == r_t) ? cx_new : r_ct;
    assign pair_sub = (r_pair >= PAIR_W'(cx_new)) ? r_pair - PAIR_W'(cx_new) : '0;

    assign fin_sel = r_full ? w_eff : r_seen;
    assign fin_num = r_full ? r_peak : r_pair;
    assign fin_den = (fin_sel < WIN_W'(2)) ? '0
                   : DEN_W'(fin_sel) * DEN_W'(fin_sel - 1'b1);

    always_comb begin
        n_state     = r_state;
        n_shift     = r_shift;
        n_primed    = r_primed;
        n_pos       = r_pos;
        n_seen      = r_seen;
        n_pair      = r_pair;
        n_peak      = r_peak;
        n_full      = r_full;
        n_out_valid = out_take ? 1'b0 : r_out_valid;
        cnt_rd_en   = 1'b0;
        cnt_rd_addr = shift_nx;
        cnt_wr_en   = 1'b0;
        cnt_wr_addr = r_t;
        cnt_wr_data = cnt_inc(r_ct);
        cnt_clear   = 1'b0;
        ring_rd_en  = 1'b0;
        ring_wr_en  = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (!bmap[2]) begin
                        n_shift = shift_nx;
                        if (r_primed < 2'd2) begin
                            n_primed = r_primed + 1'b1;
                            n_state  = i_base.last_base ? ST_FIN : ST_IDLE;
                        end else begin
                            cnt_rd_en  = 1'b1;
                            ring_rd_en = 1'b1;
                            n_state    = ST_RD1;
                        end
                    end else begin
                        n_state = i_base.last_base ? ST_FIN : ST_IDLE;
                    end
                end
            end
            ST_RD1: begin
                if (r_slide) begin
                    cnt_rd_en   = 1'b1;
                    cnt_rd_addr = r_ring_q;
                    n_state     = ST_RD2;
                end else begin
                    n_pair      = pair_add(r_pair, cnt_val);
                    cnt_wr_en   = 1'b1;
                    cnt_wr_data = cnt_inc(cnt_val);
                    n_seen      = r_seen + 1'b1;
                    ring_wr_en  = 1'b1;
                    n_pos       = pos_adv;
                    n_state     = r_last ? ST_FIN : ST_IDLE;
                end
            end
            ST_RD2: begin
                n_pair      = pair_add(pair_sub, ct_eff);
                cnt_wr_en   = cx_nz;
                cnt_wr_addr = r_x;
                cnt_wr_data = cx_new;
                n_state     = ST_WRT;
            end
            ST_WRT: begin
                cnt_wr_en  = 1'b1;
                n_peak     = (r_pair > r_peak) ? r_pair : r_peak;
                n_full     = 1'b1;
                ring_wr_en = 1'b1;
                n_pos      = pos_adv;
                n_state    = r_last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                cnt_clear = 1'b1;
                n_shift   = '0;
                n_primed  = '0;
                n_pos     = '0;
                n_seen    = '0;
                n_pair    = '0;
                n_peak    = '0;
                n_full    = 1'b0;
                n_state   = ST_DSTART;
            end
            ST_DSTART: begin
                n_state = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_stat.done && (!r_out_valid || o_score.ready)) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_window_length <= W_RESET;
            r_shift         <= '0;
            r_primed        <= '0;
            r_pos           <= '0;
            r_seen          <= '0;
            r_pair          <= '0;
            r_peak          <= '0;
            r_full          <= 1'b0;
            r_out_valid     <= 1'b0;
            r_slide         <= 1'b0;
            r_last          <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_shift     <= n_shift;
            r_primed    <= n_primed;
            r_pos       <= n_pos;
            r_seen      <= n_seen;
            r_pair      <= n_pair;
            r_peak      <= n_peak;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_window_length <= i_cfg_wr_data;
            end
            if (in_take) begin
                r_slide <= (r_seen >= w_eff);
                r_last  <= i_base.last_base;
            end
        end
    end

    // count valid bits: a clear empties every entry at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
        end else if (cnt_clear) begin
            r_cnt_vld <= '0;
        end else if (cnt_wr_en) begin
            r_cnt_vld[cnt_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_wr_en) begin
            cnt_mem[cnt_wr_addr] <= cnt_wr_data;
        end
        if (cnt_rd_en) begin
            r_cnt_q  <= cnt_mem[cnt_rd_addr];
            r_cnt_qv <= r_cnt_vld[cnt_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_wr_en) begin
            ring_mem[r_pos_cur] <= r_t;
        end
        if (ring_rd_en) begin
            r_ring_q <= ring_mem[pos_eff];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_t       <= shift_nx;
            r_pos_cur <= pos_eff;
        end
        if (r_state == ST_RD1) begin
            r_ct <= cnt_val;
            r_x  <= r_ring_q;
        end
        if (r_state == ST_RD2) begin
            r_ct <= ct_eff;
        end
        if (r_state == ST_FIN) begin
            r_den     <= fin_den;
            r_num     <= (fin_num >= NUM_CAP) ? NUM_W'(NUM_CAP) : NUM_W'(fin_num);
            r_pk_used <= (fin_num > PAIR_W'(PEAK_MAX)) ? PEAK_MAX : PEAK_W'(fin_num);
            r_filled  <= r_full;
        end
        if (out_load) begin
            r_out_dust   <= div_quot;
            r_out_peak   <= r_pk_used;
            r_out_filled <= r_filled;
        end
    end

    dlcs_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DSTART),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

    assign o_score.valid           = r_out_valid;
    assign o_score.dust_score      = r_out_dust;
    assign o_score.peak_pair_score = r_out_peak;
    assign o_score.window_filled   = r_out_filled;

    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DSTART) |-> !div_stat.busy)
        else $error("divider started while busy");

    a_seen_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= WIN_W'(WINDOW_MAX))
        else $error("triplet count beyond window capacity");

    a_counts_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (r_cnt_vld == '0))
        else $error("count table not cleared after read");

    a_full_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_seen >= WIN_W'(W_MIN)))
        else $error("sliding phase without a filled window");

endmodule

@@ src/dlcs_div.sv @@
// restoring divider for the saturated percentage num * 51200 / den
module dlcs_div
    import dlcs_pkg::*;
#(
    parameter int NUM_W = 15,
    parameter int DEN_W = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic [SCORE_W-1:0] o_quot,
    output t_div_stat          o_stat
);

    localparam int N_W     = NUM_W + 16;
    localparam int STEP_N  = SCORE_W + 1;
    localparam int STEP_CW = $clog2(STEP_N);
    localparam logic [STEP_CW-1:0] STEP_LAST = STEP_CW'(STEP_N - 1);

    logic [N_W-1:0]     r_rem;
    logic [N_W-1:0]     r_dsh;
    logic [STEP_N-1:0]  r_q;
    logic [STEP_CW-1:0] r_step;
    logic               r_zero;
    logic               r_busy;
    logic               r_done;

    logic [N_W-1:0] num_ext;
    logic [N_W-1:0] scaled;
    logic           fits;

    // 51200 = 2^15 + 2^14 + 2^11
    assign num_ext = N_W'(i_num);
    assign scaled  = (num_ext << 15) + (num_ext << 14) + (num_ext << 11);
    assign fits    = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= scaled;
            r_dsh  <= N_W'(i_den) << SCORE_W;
            r_q    <= '0;
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[STEP_N-2:0], fits};
            r_dsh <= r_dsh >> 1;
        end
    end

    always_comb begin
        priority if (r_zero) begin
            o_quot = '0;
        end else if (r_q[SCORE_W]) begin
            o_quot = PCT_MAX;
        end else begin
            o_quot = r_q[SCORE_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
